>>> hw/rtl/rdt_pkg.sv
// Shared types, codes and keyword table for the rules DSL tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none
package rdt_pkg;

    localparam int KW_COUNT = 14;

    // record types
    localparam logic [1:0] RT_VALUE = 2'd0;
    localparam logic [1:0] RT_TOKEN = 2'd1;
    localparam logic [1:0] RT_ERROR = 2'd2;

    // token kinds (keywords are 0..13)
    localparam logic [4:0] TK_LBRACE   = 5'd14;
    localparam logic [4:0] TK_RBRACE   = 5'd15;
    localparam logic [4:0] TK_LPAREN   = 5'd16;
    localparam logic [4:0] TK_RPAREN   = 5'd17;
    localparam logic [4:0] TK_LBRACKET = 5'd18;
    localparam logic [4:0] TK_RBRACKET = 5'd19;
    localparam logic [4:0] TK_SEMI     = 5'd20;
    localparam logic [4:0] TK_COMMA    = 5'd21;
    localparam logic [4:0] TK_ASSIGN   = 5'd22;
    localparam logic [4:0] TK_ARROW    = 5'd23;
    localparam logic [4:0] TK_EQEQ     = 5'd24;
    localparam logic [4:0] TK_NEQ      = 5'd25;
    localparam logic [4:0] TK_IDENT    = 5'd26;
    localparam logic [4:0] TK_STRING   = 5'd27;
    localparam logic [4:0] TK_NUMBER   = 5'd28;
    localparam logic [4:0] TK_END      = 5'd29;
    localparam logic [4:0] TK_NONE     = 5'd0;

    // error codes
    localparam logic [1:0] ERR_UNEXPECTED = 2'd0;
    localparam logic [1:0] ERR_ESCAPE     = 2'd1;
    localparam logic [1:0] ERR_UNTERM     = 2'd2;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        {16'd0, "runtime"}, "construct", {40'd0, "when"}, "otherwise",
        {48'd0, "let"}, {40'd0, "call"}, {40'd0, "emit"}, {48'd0, "has"},
        {48'd0, "and"}, {56'd0, "or"}, {48'd0, "not"}, {40'd0, "true"},
        {32'd0, "false"}, {24'd0, "branch"}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd9, 4'd4, 4'd9, 4'd3, 4'd4, 4'd4,
        4'd3, 4'd3, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6
    };

    // classified source transaction
    typedef struct packed {
        logic       action;
        logic [7:0] ch;
        logic       is_space;
        logic       is_nl;
        logic [4:0] punct;
        logic       is_digit;
        logic       is_word_start;
        logic       is_word;
        logic       is_slash;
        logic       is_eq;
        logic       is_bang;
        logic       is_quote;
        logic       is_bslash;
        logic       is_star;
        logic       is_gt;
        logic       esc_ok;
        logic [7:0] esc_val;
    } cls_t;

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] idx);
        logic [71:0] txt;
        logic [3:0]  len;
        int unsigned sh;
        txt = KW_TEXT[k];
        len = KW_LEN[k];
        sh  = 0;
        if (idx >= len) begin
            return 8'd0;
        end
        sh = 8 * (int'(len) - int'(idx) - 1);
        return txt[sh +: 8];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rules_dsl_tokenizer_core.sv
// Rules DSL tokenizer: front classifier, two-entry queue, lexer back end.
// A transaction is registered in the queue, and its results in the result buffer, before they reach m_.
// Throughput: one byte per cycle while each byte yields at most one result and m_ready is held
// high; the result buffer drains one result per cycle, so second results of a byte back up in it, and
// the input stalls once the result buffer holds more than two. Synchronous active-low
// reset empties both buffers and returns the lexer to normal scanning at line 1, column 1.
`default_nettype none
module rules_dsl_tokenizer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [7:0]  s_char_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_record_type,
    output logic [4:0]       m_token_kind,
    output logic [1:0]       m_error_code,
    output logic [7:0]       m_value_byte,
    output logic [15:0]      m_line_number,
    output logic [15:0]      m_column_number,
    output logic             m_last
);
    import rdt_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    cls_t push_data, pop_data;

    rdt_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_char_code (s_char_code),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    rdt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rdt_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (pop_valid),
        .q_ready         (pop_ready),
        .q_data          (pop_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_type   (m_record_type),
        .m_token_kind    (m_token_kind),
        .m_error_code    (m_error_code),
        .m_value_byte    (m_value_byte),
        .m_line_number   (m_line_number),
        .m_column_number (m_column_number),
        .m_last          (m_last)
    );

endmodule
`default_nettype wire

>>> hw/rtl/rdt_front.sv
// Front end: takes source transactions and classifies each byte.
// Depends on rdt_pkg; feeds rdt_queue.
`default_nettype none
module rdt_front (
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_action,
    input  wire logic [7:0]   s_char_code,
    output logic              push_valid,
    input  wire logic         push_ready,
    output rdt_pkg::cls_t     push_data
);
    import rdt_pkg::*;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;

    logic [7:0] c;
    logic       alpha;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        c = s_char_code;
        alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        push_data.action        = s_action;
        push_data.ch            = c;
        push_data.is_nl         = (c == CH_NL);
        push_data.is_space      = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR)
                                  || (c == CH_NL);
        push_data.is_digit      = (c >= 8'h30 && c <= 8'h39);
        push_data.is_word_start = alpha || (c == CH_UNDER);
        push_data.is_word       = alpha || (c == CH_UNDER) || (c >= 8'h30 && c <= 8'h39);
        push_data.is_slash      = (c == CH_SLASH);
        push_data.is_eq         = (c == CH_EQ);
        push_data.is_bang       = (c == CH_BANG);
        push_data.is_quote      = (c == CH_QUOTE);
        push_data.is_bslash     = (c == CH_BSLASH);
        push_data.is_star       = (c == CH_STAR);
        push_data.is_gt         = (c == CH_GT);
        case (c)
            CH_LBRACE: push_data.punct = TK_LBRACE;
            CH_RBRACE: push_data.punct = TK_RBRACE;
            CH_LPAREN: push_data.punct = TK_LPAREN;
            CH_RPAREN: push_data.punct = TK_RPAREN;
            CH_LBRK:   push_data.punct = TK_LBRACKET;
            CH_RBRK:   push_data.punct = TK_RBRACKET;
            CH_SEMI:   push_data.punct = TK_SEMI;
            CH_COMMA:  push_data.punct = TK_COMMA;
            default:   push_data.punct = TK_NONE;
        endcase
        case (c)
            CH_QUOTE:  begin push_data.esc_ok = 1'b1; push_data.esc_val = CH_QUOTE;  end
            CH_BSLASH: begin push_data.esc_ok = 1'b1; push_data.esc_val = CH_BSLASH; end
            CH_N:      begin push_data.esc_ok = 1'b1; push_data.esc_val = CH_NL;     end
            CH_T:      begin push_data.esc_ok = 1'b1; push_data.esc_val = CH_TAB;    end
            default:   begin push_data.esc_ok = 1'b0; push_data.esc_val = 8'd0;      end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/rdt_queue.sv
// Two-entry queue of classified transactions between front and back end.
// Depends on rdt_pkg.
`default_nettype none
module rdt_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire rdt_pkg::cls_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output rdt_pkg::cls_t      pop_data
);
    import rdt_pkg::*;

    cls_t       data_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = data_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_next  = do_push ? ~wr_reg : wr_reg;
        rd_next  = do_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (do_push) begin
            data_reg[wr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (cnt_reg != 2'd0))
        else $error("queue lost an entry");

endmodule
`default_nettype wire

>>> hw/rtl/rdt_back.sv
// Back end: lexer state machine plus a four-entry result buffer.
// Depends on rdt_pkg; consumes classified transactions from rdt_queue.
`default_nettype none
module rdt_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire rdt_pkg::cls_t q_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_record_type,
    output logic [4:0]         m_token_kind,
    output logic [1:0]         m_error_code,
    output logic [7:0]         m_value_byte,
    output logic [15:0]        m_line_number,
    output logic [15:0]        m_column_number,
    output logic               m_last
);
    import rdt_pkg::*;

    typedef enum logic [3:0] {
        M_NORMAL, M_IDENT, M_NUMBER, M_STRING, M_ESCAPE, M_EQ, M_BANG,
        M_SLASH, M_LINE, M_BLOCK, M_ERROR
    } mode_t;

    typedef enum logic [1:0] { H_NONE, H_STAR, H_NL, H_OTHER } held_t;

    typedef struct packed {
        logic [1:0]  rtype;
        logic [4:0]  kind;
        logic [1:0]  err;
        logic [7:0]  vbyte;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } res_t;

    mode_t       mode_reg, mode_next;
    held_t       held_reg, held_next;
    logic [15:0] line_reg, line_next, col_reg, col_next;
    logic [15:0] tl_reg, tl_next, tc_reg, tc_next;
    logic [13:0] mask_reg, mask_next;
    logic [3:0]  len_reg, len_next;

    res_t        fifo_reg [4];
    logic [1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [2:0]  cnt_reg, cnt_next;

    res_t        res_v [2];
    logic [1:0]  n_v;
    logic        do_scan, do_adv, do_nl, clear_all, cont;
    logic        take, out_pop;
    logic [1:0]  push_n;
    cls_t        h;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic res_t mk(input logic [1:0] rt, input logic [4:0] kind,
                                input logic [1:0] err, input logic [7:0] b,
                                input logic [15:0] ln, input logic [15:0] cl);
        res_t r;
        r.rtype = rt;
        r.kind  = kind;
        r.err   = err;
        r.vbyte = b;
        r.line  = ln;
        r.col   = cl;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic [13:0] kw_filter(input logic [13:0] mask,
                                              input logic [3:0] len,
                                              input logic [7:0] c);
        logic [13:0] m;
        m = mask;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (len >= KW_LEN[k] || kw_char(4'(k), len) != c) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [4:0] word_kind(input logic ident, input logic [13:0] mask,
                                             input logic [3:0] len);
        logic [4:0] kind;
        kind = ident ? TK_IDENT : TK_NUMBER;
        if (ident) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (mask[k] && len == KW_LEN[k]) begin
                    kind = 5'(k);
                end
            end
        end
        return kind;
    endfunction

    always_comb begin
        h         = q_data;
        mode_next = mode_reg;
        held_next = held_reg;
        tl_next   = tl_reg;
        tc_next   = tc_reg;
        mask_next = mask_reg;
        len_next  = len_reg;
        n_v       = 2'd0;
        res_v[0]  = mk(RT_VALUE, TK_NONE, ERR_UNEXPECTED, 8'd0, 16'd0, 16'd0);
        res_v[1]  = res_v[0];
        do_scan   = 1'b0;
        do_adv    = 1'b0;
        do_nl     = 1'b0;
        clear_all = 1'b0;
        cont      = 1'b0;
        if (h.action) begin
            case (mode_reg)
                M_IDENT, M_NUMBER: begin
                    res_v[0] = mk(RT_TOKEN, word_kind(mode_reg == M_IDENT, mask_reg, len_reg),
                                  ERR_UNEXPECTED, 8'd0, tl_reg, tc_reg);
                    n_v = 2'd1;
                    mode_next = M_NORMAL;
                end
                M_STRING, M_ESCAPE: begin
                    res_v[0] = mk(RT_ERROR, TK_NONE, ERR_UNTERM, 8'd0, tl_reg, tc_reg);
                    n_v = 2'd1;
                    mode_next = M_ERROR;
                end
                M_EQ: begin
                    res_v[0] = mk(RT_TOKEN, TK_ASSIGN, ERR_UNEXPECTED, 8'd0, tl_reg, tc_reg);
                    n_v = 2'd1;
                    mode_next = M_NORMAL;
                end
                M_BANG: begin
                    res_v[0] = mk(RT_ERROR, TK_NONE, ERR_UNEXPECTED, CH_BANG, tl_reg, tc_reg);
                    n_v = 2'd1;
                    mode_next = M_ERROR;
                end
                M_SLASH: begin
                    res_v[0] = mk(RT_ERROR, TK_NONE, ERR_UNEXPECTED, CH_SLASH, tl_reg, tc_reg);
                    n_v = 2'd1;
                    mode_next = M_ERROR;
                end
                default: ;
            endcase
            if (mode_next != M_ERROR) begin
                res_v[n_v[0]] = mk(RT_TOKEN, TK_END, ERR_UNEXPECTED, 8'd0, line_reg, col_reg);
                n_v = n_v + 2'd1;
            end
            clear_all = 1'b1;
        end else begin
            case (mode_reg)
                M_IDENT, M_NUMBER: begin
                    cont = (mode_reg == M_NUMBER) ? h.is_digit : h.is_word;
                    if (cont) begin
                        if (mode_reg == M_IDENT) begin
                            mask_next = kw_filter(mask_reg, len_reg, h.ch);
                            len_next  = (len_reg == 4'hF) ? len_reg : len_reg + 4'd1;
                        end
                        res_v[0] = mk(RT_VALUE, TK_NONE, ERR_UNEXPECTED, h.ch, tl_reg, tc_reg);
                        n_v = 2'd1;
                        do_adv = 1'b1;
                    end else begin
                        res_v[0] = mk(RT_TOKEN,
                                      word_kind(mode_reg == M_IDENT, mask_reg, len_reg),
                                      ERR_UNEXPECTED, 8'd0, tl_reg, tc_reg);
                        n_v = 2'd1;
                        mode_next = M_NORMAL;
                        do_scan = 1'b1;
                    end
                end
                M_STRING: begin
                    do_adv = 1'b1;
                    if (h.is_quote) begin
                        res_v[0] = mk(RT_TOKEN, TK_STRING, ERR_UNEXPECTED, 8'd0,
                                      tl_reg, tc_reg);
                        n_v = 2'd1;
                        mode_next = M_NORMAL;
                    end else if (h.is_bslash) begin
                        mode_next = M_ESCAPE;
                    end else begin
                        res_v[0] = mk(RT_VALUE, TK_NONE, ERR_UNEXPECTED, h.ch, tl_reg, tc_reg);
                        n_v = 2'd1;
                    end
                end
                M_ESCAPE: begin
                    do_adv = 1'b1;
                    n_v = 2'd1;
                    if (h.esc_ok) begin
                        res_v[0] = mk(RT_VALUE, TK_NONE, ERR_UNEXPECTED, h.esc_val,
                                      tl_reg, tc_reg);
                        mode_next = M_STRING;
                    end else begin
                        res_v[0] = mk(RT_ERROR, TK_NONE, ERR_ESCAPE, h.ch, tl_reg, tc_reg);
                        mode_next = M_ERROR;
                    end
                end
                M_EQ: begin
                    n_v = 2'd1;
                    mode_next = M_NORMAL;
                    if (h.is_gt || h.is_eq) begin
                        res_v[0] = mk(RT_TOKEN, h.is_gt ? TK_ARROW : TK_EQEQ,
                                      ERR_UNEXPECTED, 8'd0, tl_reg, tc_reg);
                        do_adv = 1'b1;
                    end else begin
                        res_v[0] = mk(RT_TOKEN, TK_ASSIGN, ERR_UNEXPECTED, 8'd0,
                                      tl_reg, tc_reg);
                        do_scan = 1'b1;
                    end
                end
                M_BANG: begin
                    n_v = 2'd1;
                    if (h.is_eq) begin
                        res_v[0] = mk(RT_TOKEN, TK_NEQ, ERR_UNEXPECTED, 8'd0, tl_reg, tc_reg);
                        do_adv = 1'b1;
                        mode_next = M_NORMAL;
                    end else begin
                        res_v[0] = mk(RT_ERROR, TK_NONE, ERR_UNEXPECTED, CH_BANG,
                                      tl_reg, tc_reg);
                        mode_next = M_ERROR;
                    end
                end
                M_SLASH: begin
                    if (h.is_slash) begin
                        mode_next = M_LINE;
                    end else if (h.is_star) begin
                        mode_next = M_BLOCK;
                        held_next = H_NONE;
                    end else begin
                        res_v[0] = mk(RT_ERROR, TK_NONE, ERR_UNEXPECTED, CH_SLASH,
                                      tl_reg, tc_reg);
                        n_v = 2'd1;
                        mode_next = M_ERROR;
                    end
                end
                M_LINE: begin
                    if (h.is_nl) begin
                        do_nl = 1'b1;
                        mode_next = M_NORMAL;
                    end
                end
                M_BLOCK: begin
                    if (held_reg == H_STAR && h.is_slash) begin
                        held_next = H_NONE;
                        mode_next = M_NORMAL;
                    end else begin
                        do_nl = (held_reg == H_NL);
                        held_next = h.is_star ? H_STAR : (h.is_nl ? H_NL : H_OTHER);
                    end
                end
                M_ERROR: ;
                default: do_scan = 1'b1;
            endcase

            if (do_scan) begin
                if (h.is_space) begin
                    do_adv = 1'b1;
                end else if (h.punct != TK_NONE) begin
                    res_v[n_v[0]] = mk(RT_TOKEN, h.punct, ERR_UNEXPECTED, 8'd0,
                                       line_reg, col_reg);
                    n_v = n_v + 2'd1;
                    do_adv = 1'b1;
                end else if (h.is_slash) begin
                    tl_next = line_reg;
                    tc_next = col_reg;
                    mode_next = M_SLASH;
                end else if (h.is_eq || h.is_bang || h.is_quote) begin
                    tl_next = line_reg;
                    tc_next = col_reg;
                    do_adv = 1'b1;
                    mode_next = h.is_eq ? M_EQ : (h.is_bang ? M_BANG : M_STRING);
                end else if (h.is_digit || h.is_word_start) begin
                    tl_next = line_reg;
                    tc_next = col_reg;
                    res_v[n_v[0]] = mk(RT_VALUE, TK_NONE, ERR_UNEXPECTED, h.ch,
                                       line_reg, col_reg);
                    n_v = n_v + 2'd1;
                    do_adv = 1'b1;
                    if (h.is_digit) begin
                        mode_next = M_NUMBER;
                    end else begin
                        mask_next = kw_filter(14'h3FFF, 4'd0, h.ch);
                        len_next  = 4'd1;
                        mode_next = M_IDENT;
                    end
                end else begin
                    res_v[n_v[0]] = mk(RT_ERROR, TK_NONE, ERR_UNEXPECTED, h.ch,
                                       line_reg, col_reg);
                    n_v = n_v + 2'd1;
                    mode_next = M_ERROR;
                end
            end
        end

        if (n_v == 2'd1) begin
            res_v[0].last = 1'b1;
        end else if (n_v == 2'd2) begin
            res_v[1].last = 1'b1;
        end

        line_next = line_reg;
        col_next  = col_reg;
        if (clear_all) begin
            mode_next = M_NORMAL;
            held_next = H_NONE;
            line_next = 16'd1;
            col_next  = 16'd1;
            tl_next   = 16'd1;
            tc_next   = 16'd1;
            mask_next = 14'h3FFF;
            len_next  = 4'd0;
        end else if (do_nl || (do_adv && h.is_nl)) begin
            line_next = sat_inc(line_reg);
            col_next  = 16'd1;
        end else if (do_adv) begin
            col_next = sat_inc(col_reg);
        end
    end

    assign q_ready = (cnt_reg <= 3'd2);
    assign take    = q_valid && q_ready;
    assign m_valid = (cnt_reg != 3'd0);
    assign out_pop = m_valid && m_ready;
    assign push_n  = take ? n_v : 2'd0;

    always_comb begin
        wr_next  = wr_reg + push_n;
        rd_next  = out_pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + {1'b0, push_n} - {2'b00, out_pop};
    end

    assign m_record_type   = fifo_reg[rd_reg].rtype;
    assign m_token_kind    = fifo_reg[rd_reg].kind;
    assign m_error_code    = fifo_reg[rd_reg].err;
    assign m_value_byte    = fifo_reg[rd_reg].vbyte;
    assign m_line_number   = fifo_reg[rd_reg].line;
    assign m_column_number = fifo_reg[rd_reg].col;
    assign m_last          = fifo_reg[rd_reg].last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_NORMAL;
            held_reg <= H_NONE;
            line_reg <= 16'd1;
            col_reg  <= 16'd1;
            tl_reg   <= 16'd1;
            tc_reg   <= 16'd1;
            mask_reg <= 14'h3FFF;
            len_reg  <= 4'd0;
            wr_reg   <= 2'd0;
            rd_reg   <= 2'd0;
            cnt_reg  <= 3'd0;
        end else begin
            if (take) begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                line_reg <= line_next;
                col_reg  <= col_next;
                tl_reg   <= tl_next;
                tc_reg   <= tc_next;
                mask_reg <= mask_next;
                len_reg  <= len_next;
            end
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (take && n_v != 2'd0) begin
            fifo_reg[wr_reg] <= res_v[0];
        end
        if (take && n_v == 2'd2) begin
            fifo_reg[wr_reg + 2'd1] <= res_v[1];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 3'd4)
        else $error("result buffer overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && mode_reg == M_ERROR && !q_data.action) |-> (n_v == 2'd0))
        else $error("result produced after an error");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (line_reg != 16'd0) && (col_reg != 16'd0) && (tl_reg != 16'd0) && (tc_reg != 16'd0))
        else $error("position counter wrapped to zero");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_data.action) |=>
        (mode_reg == M_NORMAL && line_reg == 16'd1 && col_reg == 16'd1 && len_reg == 4'd0))
        else $error("state not restored after end of source");

endmodule
`default_nettype wire

>>> tb/rules_dsl_tokenizer_core_test.sv
// Self-checking testbench for rules_dsl_tokenizer_core: a directed stimulus table, then
// random rule-language sources under changing backpressure, checked by expected records
// in the table or a built-in lexer model. Depends on rdt_pkg and the tokenizer RTL only.
module rules_dsl_tokenizer_core_test;
    import rdt_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 40;
    localparam int NUM_KW       = 14;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    localparam logic [1:0] NO_ERR  = 2'd0;
    localparam logic [7:0] NO_BYTE = 8'd0;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        LX_NORMAL, LX_IDENT, LX_NUMBER, LX_STRING, LX_ESCAPE, LX_EQ, LX_BANG,
        LX_SLASH, LX_LINE, LX_BLOCK, LX_ERROR
    } lex_mode_e;

    typedef enum logic [1:0] {BC_NONE, BC_STAR, BC_NL, BC_OTHER} block_held_e;

    typedef struct packed {
        logic [1:0]  rtype;
        logic [4:0]  kind;
        logic [1:0]  err;
        logic [7:0]  vbyte;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } tok_rec_t;

    typedef struct packed {
        logic       act;
        logic [7:0] ch;
    } src_item_t;

    typedef struct packed {
        logic       act;
        logic [7:0] ch;
        logic [16:0] reps;
        logic       typed;
        tok_rec_t   want;
    } drive_row_t;

    string kw_words [NUM_KW] = '{
        "runtime", "construct", "when", "otherwise", "let", "call", "emit",
        "has", "and", "or", "not", "true", "false", "branch"
    };
    string punct_chars = "{}()[];,";
    string block_fill  = "*/a ";

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_action    = 1'b0;
    logic [7:0]  s_char_code = 8'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_record_type;
    logic [4:0]  m_token_kind;
    logic [1:0]  m_error_code;
    logic [7:0]  m_value_byte;
    logic [15:0] m_line_number;
    logic [15:0] m_column_number;
    logic        m_last;

    rules_dsl_tokenizer_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_type   (m_record_type),
        .m_token_kind    (m_token_kind),
        .m_error_code    (m_error_code),
        .m_value_byte    (m_value_byte),
        .m_line_number   (m_line_number),
        .m_column_number (m_column_number),
        .m_last          (m_last)
    );

    // lexer model state
    lex_mode_e   lx_mode;
    logic [15:0] lx_line, lx_col, lx_tok_line, lx_tok_col;
    logic [13:0] kw_mask;
    logic [3:0]  id_len;
    block_held_e blk_held;
    tok_rec_t    step_out [$];

    tok_rec_t    pending_records [$];
    drive_row_t  directed_rows [$];
    src_item_t   stim_q [$];
    tok_rec_t    want_rec;
    int          error_count   = 0;
    int          results_seen  = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    bit          hold_armed    = 1'b0;
    bit          hold_done     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic tok_rec_t make_rec(input logic [1:0] rt, input logic [4:0] kind,
                                          input logic [1:0] err, input logic [7:0] b,
                                          input logic [15:0] ln, input logic [15:0] cl);
        tok_rec_t r;
        r.rtype = rt;
        r.kind  = kind;
        r.err   = err;
        r.vbyte = b;
        r.line  = ln;
        r.col   = cl;
        r.last  = 1'b1;
        return r;
    endfunction

    function automatic void push_rec(input logic [1:0] rt, input logic [4:0] kind,
                                     input logic [1:0] err, input logic [7:0] b,
                                     input logic [15:0] ln, input logic [15:0] cl);
        tok_rec_t r;
        r = make_rec(rt, kind, err, b, ln, cl);
        r.last = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void lex_reset();
        lx_mode     = LX_NORMAL;
        lx_line     = 16'd1;
        lx_col      = 16'd1;
        lx_tok_line = 16'd1;
        lx_tok_col  = 16'd1;
        kw_mask     = '1;
        id_len      = 4'd0;
        blk_held    = BC_NONE;
    endfunction

    function automatic bit is_digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word_c(input logic [7:0] c);
        return is_alpha_c(c) || is_digit_c(c) || c == "_";
    endfunction

    function automatic void next_line();
        if (lx_line != 16'hFFFF) lx_line++;
        lx_col = 16'd1;
    endfunction

    function automatic void advance(input logic [7:0] c);
        if (c == CH_NL) next_line();
        else if (lx_col != 16'hFFFF) lx_col++;
    endfunction

    function automatic void mark_start();
        lx_tok_line = lx_line;
        lx_tok_col  = lx_col;
    endfunction

    function automatic void push_value(input logic [7:0] c);
        push_rec(RT_VALUE, TK_NONE, NO_ERR, c, lx_tok_line, lx_tok_col);
    endfunction

    function automatic void fail_at_start(input logic [1:0] code, input logic [7:0] b);
        push_rec(RT_ERROR, TK_NONE, code, b, lx_tok_line, lx_tok_col);
        lx_mode = LX_ERROR;
    endfunction

    function automatic void kw_track(input logic [7:0] c);
        for (int k = 0; k < NUM_KW; k++) begin
            if (id_len >= kw_words[k].len() || kw_words[k][id_len] != c) kw_mask[k] = 1'b0;
        end
        if (id_len < 4'd15) id_len++;
    endfunction

    function automatic void finish_word();
        logic [4:0] kind;
        kind = (lx_mode == LX_NUMBER) ? TK_NUMBER : TK_IDENT;
        if (lx_mode == LX_IDENT) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (kw_mask[k] && id_len == kw_words[k].len()) kind = 5'(k);
            end
        end
        push_rec(RT_TOKEN, kind, NO_ERR, NO_BYTE, lx_tok_line, lx_tok_col);
        lx_mode = LX_NORMAL;
    endfunction

    function automatic void scan(input logic [7:0] c);
        logic [4:0] punct;
        case (c)
            "{":     punct = TK_LBRACE;
            "}":     punct = TK_RBRACE;
            "(":     punct = TK_LPAREN;
            ")":     punct = TK_RPAREN;
            "[":     punct = TK_LBRACKET;
            "]":     punct = TK_RBRACKET;
            ";":     punct = TK_SEMI;
            ",":     punct = TK_COMMA;
            default: punct = TK_NONE;
        endcase
        if (c == " " || c == CH_TAB || c == CH_CR || c == CH_NL) begin
            advance(c);
        end else if (punct != TK_NONE) begin
            push_rec(RT_TOKEN, punct, NO_ERR, NO_BYTE, lx_line, lx_col);
            advance(c);
        end else if (c == CH_SLASH) begin
            mark_start();
            lx_mode = LX_SLASH;
        end else if (c == "=") begin
            mark_start();
            advance(c);
            lx_mode = LX_EQ;
        end else if (c == CH_BANG) begin
            mark_start();
            advance(c);
            lx_mode = LX_BANG;
        end else if (c == CH_QUOTE) begin
            mark_start();
            advance(c);
            lx_mode = LX_STRING;
        end else if (is_digit_c(c)) begin
            mark_start();
            push_value(c);
            advance(c);
            lx_mode = LX_NUMBER;
        end else if (is_alpha_c(c) || c == "_") begin
            mark_start();
            kw_mask = '1;
            id_len  = 4'd0;
            kw_track(c);
            push_value(c);
            advance(c);
            lx_mode = LX_IDENT;
        end else begin
            push_rec(RT_ERROR, TK_NONE, ERR_UNEXPECTED, c, lx_line, lx_col);
            lx_mode = LX_ERROR;
        end
    endfunction

    // Computes the records one source transaction produces into step_out.
    function automatic void lex_step(input logic act, input logic [7:0] c);
        step_out.delete();
        if (act == ACT_EOS) begin
            case (lx_mode)
                LX_IDENT, LX_NUMBER: finish_word();
                LX_STRING, LX_ESCAPE: fail_at_start(ERR_UNTERM, NO_BYTE);
                LX_EQ: begin
                    push_rec(RT_TOKEN, TK_ASSIGN, NO_ERR, NO_BYTE, lx_tok_line, lx_tok_col);
                    lx_mode = LX_NORMAL;
                end
                LX_BANG:  fail_at_start(ERR_UNEXPECTED, CH_BANG);
                LX_SLASH: fail_at_start(ERR_UNEXPECTED, CH_SLASH);
                default: ;
            endcase
            if (lx_mode != LX_ERROR) push_rec(RT_TOKEN, TK_END, NO_ERR, NO_BYTE, lx_line, lx_col);
            lex_reset();
        end else begin
            case (lx_mode)
                LX_IDENT, LX_NUMBER: begin
                    if (lx_mode == LX_NUMBER ? is_digit_c(c) : is_word_c(c)) begin
                        if (lx_mode == LX_IDENT) kw_track(c);
                        push_value(c);
                        advance(c);
                    end else begin
                        finish_word();
                        scan(c);
                    end
                end
                LX_STRING: begin
                    if (c == CH_QUOTE) begin
                        push_rec(RT_TOKEN, TK_STRING, NO_ERR, NO_BYTE, lx_tok_line, lx_tok_col);
                        advance(c);
                        lx_mode = LX_NORMAL;
                    end else if (c == CH_BSLASH) begin
                        advance(c);
                        lx_mode = LX_ESCAPE;
                    end else begin
                        push_value(c);
                        advance(c);
                    end
                end
                LX_ESCAPE: begin
                    advance(c);
                    if (c == CH_QUOTE || c == CH_BSLASH) begin
                        push_value(c);
                        lx_mode = LX_STRING;
                    end else if (c == "n") begin
                        push_value(CH_NL);
                        lx_mode = LX_STRING;
                    end else if (c == "t") begin
                        push_value(CH_TAB);
                        lx_mode = LX_STRING;
                    end else begin
                        fail_at_start(ERR_ESCAPE, c);
                    end
                end
                LX_EQ: begin
                    if (c == ">" || c == "=") begin
                        push_rec(RT_TOKEN, (c == ">") ? TK_ARROW : TK_EQEQ, NO_ERR, NO_BYTE,
                                 lx_tok_line, lx_tok_col);
                        advance(c);
                        lx_mode = LX_NORMAL;
                    end else begin
                        push_rec(RT_TOKEN, TK_ASSIGN, NO_ERR, NO_BYTE, lx_tok_line, lx_tok_col);
                        lx_mode = LX_NORMAL;
                        scan(c);
                    end
                end
                LX_BANG: begin
                    if (c == "=") begin
                        push_rec(RT_TOKEN, TK_NEQ, NO_ERR, NO_BYTE, lx_tok_line, lx_tok_col);
                        advance(c);
                        lx_mode = LX_NORMAL;
                    end else begin
                        fail_at_start(ERR_UNEXPECTED, CH_BANG);
                    end
                end
                LX_SLASH: begin
                    if (c == CH_SLASH) begin
                        lx_mode = LX_LINE;
                    end else if (c == "*") begin
                        lx_mode  = LX_BLOCK;
                        blk_held = BC_NONE;
                    end else begin
                        fail_at_start(ERR_UNEXPECTED, CH_SLASH);
                    end
                end
                LX_LINE: begin
                    if (c == CH_NL) begin
                        next_line();
                        lx_mode = LX_NORMAL;
                    end
                end
                LX_BLOCK: begin
                    // a newline in a block comment counts only once another byte follows
                    if (blk_held == BC_STAR && c == CH_SLASH) begin
                        blk_held = BC_NONE;
                        lx_mode  = LX_NORMAL;
                    end else begin
                        if (blk_held == BC_NL) next_line();
                        blk_held = (c == "*") ? BC_STAR : (c == CH_NL) ? BC_NL : BC_OTHER;
                    end
                end
                LX_ERROR: ;
                default: scan(c);
            endcase
        end
        if (step_out.size() != 0) begin
            step_out[step_out.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_seen, name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_records.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want_rec = pending_records.pop_front();
                compare_field("record_type", 16'(m_record_type), 16'(want_rec.rtype));
                compare_field("token_kind", 16'(m_token_kind), 16'(want_rec.kind));
                compare_field("error_code", 16'(m_error_code), 16'(want_rec.err));
                compare_field("value_byte", 16'(m_value_byte), 16'(want_rec.vbyte));
                compare_field("line_number", m_line_number, want_rec.line);
                compare_field("column_number", m_column_number, want_rec.col);
                compare_field("last", 16'(m_last), 16'(want_rec.last));
            end
        end
    end

    // result side: random backpressure, plus one long hold-off when armed
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic send_item(input logic act, input logic [7:0] ch, input logic typed,
                             input tok_rec_t want);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_char_code <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lex_step(act, ch);
        if (typed) pending_records.insert(pending_records.size(), want);
        else foreach (step_out[i]) pending_records.insert(pending_records.size(), step_out[i]);
    endtask

    function automatic void add_row(input logic act, input logic [7:0] ch, input int reps,
                                    input logic typed, input tok_rec_t want);
        drive_row_t row;
        row.act   = act;
        row.ch    = ch;
        row.reps  = 17'(reps);
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void push_char(input logic [7:0] c);
        stim_q.insert(stim_q.size(), src_item_t'({ACT_CHAR, c}));
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int p;
        p = $urandom_range(0, 62);
        if (p < 26) return 8'("a" + p);
        if (p < 52) return 8'("A" + p - 26);
        if (p < 62) return 8'("0" + p - 52);
        return "_";
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 3))
            0:       return " ";
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] rand_text_byte();
        return 8'($urandom_range(32, 126));
    endfunction

    // Random sources: mostly well-formed token streams, some noise and cut-off tokens.
    task automatic run_random(input int n_items, input bit with_hold);
        int        sent;
        int        n_tok;
        int        pick;
        int        len;
        string     w;
        src_item_t it;
        sent = 0;
        while (sent < n_items) begin
            n_tok = $urandom_range(0, 14);
            for (int t = 0; t < n_tok; t++) begin
                pick = $urandom_range(0, 99);
                if (pick < 14) begin
                    push_text(kw_words[$urandom_range(0, NUM_KW - 1)]);
                end else if (pick < 22) begin
                    w   = kw_words[$urandom_range(0, NUM_KW - 1)];
                    len = $urandom_range(1, w.len());
                    push_text(w.substr(0, len - 1));
                    repeat ($urandom_range(0, 2)) push_char(rand_word_char());
                end else if (pick < 34) begin
                    if ($urandom_range(0, 4) == 0) push_char("_");
                    else push_char(is_alpha_c(rand_word_char()) ? rand_word_char() : "q");
                    repeat ($urandom_range(0, 18)) push_char(rand_word_char());
                end else if (pick < 44) begin
                    repeat ($urandom_range(1, 6)) push_char(8'("0" + $urandom_range(0, 9)));
                end else if (pick < 56) begin
                    push_char(CH_QUOTE);
                    repeat ($urandom_range(0, 8)) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 55) begin
                            push_char(rand_text_byte());
                        end else if (pick < 75) begin
                            push_char(CH_BSLASH);
                            case ($urandom_range(0, 3))
                                0:       push_char("n");
                                1:       push_char("t");
                                2:       push_char(CH_QUOTE);
                                default: push_char(CH_BSLASH);
                            endcase
                        end else if (pick < 80) begin
                            push_char(CH_NL);
                        end else if (pick < 83) begin
                            push_char(CH_BSLASH);
                            push_char(8'($urandom_range(0, 255)));
                        end else begin
                            push_char(8'($urandom_range(128, 255)));
                        end
                    end
                    push_char(CH_QUOTE);
                end else if (pick < 68) begin
                    push_char(punct_chars[$urandom_range(0, 7)]);
                end else if (pick < 78) begin
                    case ($urandom_range(0, 3))
                        0:       push_text("=");
                        1:       push_text("=>");
                        2:       push_text("==");
                        default: push_text("!=");
                    endcase
                end else if (pick < 84) begin
                    push_char(rand_space());
                end else if (pick < 88) begin
                    push_text("//");
                    repeat ($urandom_range(0, 6)) push_char(rand_text_byte());
                    push_char(CH_NL);
                end else if (pick < 93) begin
                    push_text("/*");
                    repeat ($urandom_range(0, 6)) begin
                        len = $urandom_range(0, 4);
                        push_char(len == 4 ? CH_NL : block_fill[len]);
                    end
                    push_text("*/");
                end else begin
                    push_char(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 99) < 70) push_char(rand_space());
            end
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 6))
                    0: begin
                        push_char(CH_QUOTE);
                        push_char("a");
                    end
                    1: begin
                        push_char(CH_QUOTE);
                        push_char(CH_BSLASH);
                    end
                    2:       push_text("/");
                    3:       push_text("!");
                    4:       push_text("=");
                    5:       push_text("/* a");
                    default: push_text("ab");
                endcase
            end
            stim_q.insert(stim_q.size(), src_item_t'({ACT_EOS, 8'($urandom_range(0, 255))}));
            while (stim_q.size() != 0) begin
                it = stim_q.pop_front();
                if (with_hold && sent == 40) hold_armed = 1'b1;
                send_item(it.act, it.ch, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        drive_row_t row;
        lex_reset();

        add_row(ACT_EOS,  NO_BYTE,   1, 1'b1,
                make_rec(RT_TOKEN, TK_END, NO_ERR, NO_BYTE, 16'd1, 16'd1));
        add_row(ACT_CHAR, 8'hFF,     1, 1'b1,
                make_rec(RT_ERROR, TK_NONE, ERR_UNEXPECTED, 8'hFF, 16'd1, 16'd1));
        add_row(ACT_EOS,  NO_BYTE,   1, 1'b0, '0);
        add_row(ACT_CHAR, 8'h00,     1, 1'b1,
                make_rec(RT_ERROR, TK_NONE, ERR_UNEXPECTED, 8'h00, 16'd1, 16'd1));
        add_row(ACT_EOS,  8'hFF,     1, 1'b0, '0);
        add_row(ACT_CHAR, CH_QUOTE,  1, 1'b0, '0);
        add_row(ACT_CHAR, 8'h80,     1, 1'b1,
                make_rec(RT_VALUE, TK_NONE, NO_ERR, 8'h80, 16'd1, 16'd1));
        add_row(ACT_CHAR, CH_BSLASH, 1, 1'b0, '0);
        add_row(ACT_CHAR, "q",       1, 1'b1,
                make_rec(RT_ERROR, TK_NONE, ERR_ESCAPE, "q", 16'd1, 16'd1));
        add_row(ACT_EOS,  NO_BYTE,   1, 1'b0, '0);
        add_row(ACT_CHAR, CH_QUOTE,  1, 1'b0, '0);
        add_row(ACT_EOS,  NO_BYTE,   1, 1'b1,
                make_rec(RT_ERROR, TK_NONE, ERR_UNTERM, NO_BYTE, 16'd1, 16'd1));
        // words across a line break, then operators and a trailing bang
        add_row(ACT_CHAR, "x",       1, 1'b1,
                make_rec(RT_VALUE, TK_NONE, NO_ERR, "x", 16'd1, 16'd1));
        add_row(ACT_CHAR, CH_NL,     1, 1'b0, '0);
        add_row(ACT_CHAR, "o",       1, 1'b1,
                make_rec(RT_VALUE, TK_NONE, NO_ERR, "o", 16'd2, 16'd1));
        add_row(ACT_CHAR, "r",       1, 1'b0, '0);
        add_row(ACT_CHAR, "=",       1, 1'b0, '0);
        add_row(ACT_CHAR, ">",       1, 1'b0, '0);
        add_row(ACT_CHAR, CH_BANG,   1, 1'b0, '0);
        add_row(ACT_CHAR, "=",       1, 1'b0, '0);
        add_row(ACT_CHAR, CH_BANG,   1, 1'b0, '0);
        add_row(ACT_EOS,  NO_BYTE,   1, 1'b0, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 7;
        sink_idle_pct = 61;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            for (int r = 0; r < int'(row.reps); r++) begin
                send_item(row.act, row.ch, row.typed, row.want);
            end
        end
        run_random(180, 1'b0);

        src_idle_pct  = 61;
        sink_idle_pct = 7;
        run_random(180, 1'b0);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(200, 1'b1);

        s_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
